// ===== rtl/pewb_pkg.sv =====
// shared constants and item types for the particle euler wall bounce core
`timescale 1ns / 1ps

package pewb_pkg;

    // fraction bits of positions, velocities and accelerations
    localparam int FRAC_BITS = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIND_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIND_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 3'd5;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_part_in;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               retire;
    } t_part_out;

endpackage

// ===== rtl/pewb_if.sv =====
// valid/ready channels of the particle euler wall bounce core
`timescale 1ns / 1ps

interface pewb_in_if;
    import pewb_pkg::*;
    logic     valid;
    logic     ready;
    t_part_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pewb_out_if;
    import pewb_pkg::*;
    logic      valid;
    logic      ready;
    t_part_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pewb_cfg_if;
    import pewb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/particle_euler_wall_bounce_core.sv =====
// top level of the particle euler wall bounce core
`timescale 1ns / 1ps

// one particle per item goes through an explicit euler step: velocity gains
// (wind_x, gravity + wind_y) * time_step, position gains new velocity *
// time_step, then each axis is clamped to [0, size-1] with its velocity negated
// and scaled by 0.6, ground friction 0.98 is applied to vx when the particle
// sits on the floor with |vy| < 2, and retire is raised for a particle resting
// near the floor. all values are signed fixed point with FRAC_BITS fraction
// bits and every sum saturates to 32 bits. the core is a nine stage pipeline
// that takes one item every cycle while stage 1 can load; the depth comes from
// four dependent multiplies (accel * dt, velocity * dt, bounce damping, floor
// friction), each followed by a register; results leave from the stage 9 register.
// every stage has its own valid bit and is loaded when it is empty or its
// successor moves on, so bubbles close up and a stalled output still lets
// items enter until all stages are full. configuration writes are always
// taken and must only happen while no item is in flight.
module particle_euler_wall_bounce_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pewb_cfg_if.sink          i_cfg,
    pewb_in_if.sink           i_part,
    pewb_out_if.source        o_part
);
    import pewb_pkg::*;

    localparam int LIM_W  = 13 + FRAC_BITS;
    localparam int CMP_W  = (LIM_W > 32) ? LIM_W : 32;
    localparam int STAGES = 9;

    localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
    localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;
    localparam logic signed [16:0] DAMP_K  = 17'sd39322;
    localparam logic signed [16:0] FRIC_K  = 17'sd64225;
    localparam logic signed [32:0] TWO_T   = 33'sd2 <<< FRAC_BITS;
    localparam logic signed [32:0] HALF_T  = 33'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [CMP_W:0] ONE_W = (CMP_W + 1)'(1) <<< FRAC_BITS;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // q16 product rounded to nearest, ties up
    function automatic logic signed [51:0] rnd16(input logic signed [49:0] p);
        logic signed [51:0] r;
        r = 52'(p >>> 16) + $signed({51'b0, p[15]});
        return r;
    endfunction

    function automatic logic below(input logic signed [31:0] v,
                                   input logic signed [32:0] t);
        logic r;
        r = (33'(v) < t) && (33'(v) > -t);
        return r;
    endfunction

    // ---------------------------------------------------------------- config
    logic signed [31:0] r_gravity;
    logic signed [31:0] r_wind_x;
    logic signed [31:0] r_wind_y;
    logic signed [31:0] r_accel_y;     // saturated gravity + wind_y
    logic [15:0]        r_time_step;
    logic [12:0]        r_area_width;
    logic [12:0]        r_area_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity     <= 32'sd1966080;
            r_wind_x      <= '0;
            r_wind_y      <= '0;
            r_accel_y     <= 32'sd1966080;
            r_time_step   <= 16'd1092;
            r_area_width  <= 13'd640;
            r_area_height <= 13'd480;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_GRAVITY: begin
                    r_gravity <= $signed(i_cfg.wdata);
                    r_accel_y <= sat32(52'($signed(i_cfg.wdata)) + 52'(r_wind_y));
                end
                CFG_WIND_X: begin
                    r_wind_x <= $signed(i_cfg.wdata);
                end
                CFG_WIND_Y: begin
                    r_wind_y  <= $signed(i_cfg.wdata);
                    r_accel_y <= sat32(52'($signed(i_cfg.wdata)) + 52'(r_gravity));
                end
                CFG_TIME_STEP: begin
                    r_time_step <= i_cfg.wdata[15:0];
                end
                CFG_AREA_WIDTH: begin
                    r_area_width <= i_cfg.wdata[12:0];
                end
                CFG_AREA_HEIGHT: begin
                    r_area_height <= i_cfg.wdata[12:0];
                end
                default: begin
                end
            endcase
        end
    end

    // wall limits, refreshed every cycle from the config registers
    logic [LIM_W-1:0]         r_xmax;
    logic [LIM_W-1:0]         r_ymax;
    logic signed [31:0]       r_xclamp;
    logic signed [31:0]       r_yclamp;
    logic signed [CMP_W:0]    r_yret;      // floor - 1.0, may be negative
    logic [12:0]              n_wlim;
    logic [12:0]              n_hlim;
    logic [LIM_W-1:0]         n_xmax;
    logic [LIM_W-1:0]         n_ymax;

    always_comb begin
        n_wlim = (r_area_width == '0) ? '0 : r_area_width - 13'd1;
        n_hlim = (r_area_height == '0) ? '0 : r_area_height - 13'd1;
        n_xmax = LIM_W'(n_wlim) << FRAC_BITS;
        n_ymax = LIM_W'(n_hlim) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        r_xmax   <= n_xmax;
        r_ymax   <= n_ymax;
        r_xclamp <= (CMP_W'(n_xmax) > CMP_W'(32'h7fffffff)) ? 32'sh7fffffff
                                                             : $signed(32'(n_xmax));
        r_yclamp <= (CMP_W'(n_ymax) > CMP_W'(32'h7fffffff)) ? 32'sh7fffffff
                                                             : $signed(32'(n_ymax));
        r_yret   <= $signed({1'b0, CMP_W'(n_ymax)}) - ONE_W;
    end

    logic signed [16:0] dt17;
    assign dt17 = $signed({1'b0, r_time_step});

    // ------------------------------------------------------ pipeline control
    logic [STAGES:1] r_vld;
    logic [STAGES:1] en;
    logic [STAGES:1] n_vld_in;

    always_comb begin
        en[STAGES] = !r_vld[STAGES] || o_part.ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld_in = {r_vld[STAGES-1:1], i_part.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld_in[k];
                end
            end
        end
    end

    assign i_part.ready = en[1];

    // stage 1: input register
    logic signed [31:0] r_s1_x, r_s1_y, r_s1_vx, r_s1_vy;
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_x  <= i_part.data.pos_x;
            r_s1_y  <= i_part.data.pos_y;
            r_s1_vx <= i_part.data.vel_x;
            r_s1_vy <= i_part.data.vel_y;
        end
    end

    // stage 2: acceleration times step length
    logic signed [31:0] r_s2_x, r_s2_y, r_s2_vx, r_s2_vy;
    logic signed [48:0] r_s2_pax, r_s2_pay;
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_vx  <= r_s1_vx;
            r_s2_vy  <= r_s1_vy;
            r_s2_pax <= r_wind_x * dt17;
            r_s2_pay <= r_accel_y * dt17;
        end
    end

    // stage 3: velocity update
    logic signed [31:0] r_s3_x, r_s3_y, r_s3_vx, r_s3_vy;
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_x  <= r_s2_x;
            r_s3_y  <= r_s2_y;
            r_s3_vx <= sat32(52'(r_s2_vx) + rnd16(50'(r_s2_pax)));
            r_s3_vy <= sat32(52'(r_s2_vy) + rnd16(50'(r_s2_pay)));
        end
    end

    // stage 4: new velocity times step length
    logic signed [31:0] r_s4_x, r_s4_y, r_s4_vx, r_s4_vy;
    logic signed [48:0] r_s4_px, r_s4_py;
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_x  <= r_s3_x;
            r_s4_y  <= r_s3_y;
            r_s4_vx <= r_s3_vx;
            r_s4_vy <= r_s3_vy;
            r_s4_px <= r_s3_vx * dt17;
            r_s4_py <= r_s3_vy * dt17;
        end
    end

    // stage 5: position update
    logic signed [31:0] r_s5_x, r_s5_y, r_s5_vx, r_s5_vy;
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_x  <= sat32(52'(r_s4_x) + rnd16(50'(r_s4_px)));
            r_s5_y  <= sat32(52'(r_s4_y) + rnd16(50'(r_s4_py)));
            r_s5_vx <= r_s4_vx;
            r_s5_vy <= r_s4_vy;
        end
    end

    // stage 6: wall tests, clamp and damping product of the negated velocity
    logic n_x_lo, n_x_hi, n_y_lo, n_y_hi;
    logic signed [32:0] n_neg_vx, n_neg_vy;
    always_comb begin
        n_x_lo   = r_s5_x[31];
        n_x_hi   = !r_s5_x[31] && (CMP_W'($unsigned(r_s5_x)) >= CMP_W'(r_xmax));
        n_y_lo   = r_s5_y[31];
        n_y_hi   = !r_s5_y[31] && (CMP_W'($unsigned(r_s5_y)) >= CMP_W'(r_ymax));
        n_neg_vx = -33'(r_s5_vx);
        n_neg_vy = -33'(r_s5_vy);
    end

    logic signed [31:0] r_s6_x, r_s6_y, r_s6_vx, r_s6_vy;
    logic               r_s6_bx, r_s6_by, r_s6_floor;
    logic signed [49:0] r_s6_pbx, r_s6_pby;
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_x     <= n_x_lo ? '0 : (n_x_hi ? r_xclamp : r_s5_x);
            r_s6_y     <= n_y_lo ? '0 : (n_y_hi ? r_yclamp : r_s5_y);
            r_s6_vx    <= r_s5_vx;
            r_s6_vy    <= r_s5_vy;
            r_s6_bx    <= n_x_lo || n_x_hi;
            r_s6_by    <= n_y_lo || n_y_hi;
            r_s6_floor <= n_y_hi;
            r_s6_pbx   <= n_neg_vx * DAMP_K;
            r_s6_pby   <= n_neg_vy * DAMP_K;
        end
    end

    // stage 7: bounced velocity
    logic signed [31:0] r_s7_x, r_s7_y, r_s7_vx, r_s7_vy;
    logic               r_s7_floor;
    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_x     <= r_s6_x;
            r_s7_y     <= r_s6_y;
            r_s7_vx    <= r_s6_bx ? sat32(rnd16(r_s6_pbx)) : r_s6_vx;
            r_s7_vy    <= r_s6_by ? sat32(rnd16(r_s6_pby)) : r_s6_vy;
            r_s7_floor <= r_s6_floor;
        end
    end

    // stage 8: friction product and the retire conditions known so far
    logic signed [31:0] r_s8_x, r_s8_y, r_s8_vx, r_s8_vy;
    logic               r_s8_fric, r_s8_ylow, r_s8_vy_half;
    logic signed [48:0] r_s8_pf;
    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_x       <= r_s7_x;
            r_s8_y       <= r_s7_y;
            r_s8_vx      <= r_s7_vx;
            r_s8_vy      <= r_s7_vy;
            r_s8_fric    <= r_s7_floor && below(r_s7_vy, TWO_T);
            r_s8_ylow    <= (CMP_W + 1)'(r_s7_y) >= r_yret;
            r_s8_vy_half <= below(r_s7_vy, HALF_T);
            r_s8_pf      <= r_s7_vx * FRIC_K;
        end
    end

    // stage 9: output register
    logic signed [31:0] n_vx_out;
    t_part_out          r_s9_out;
    assign n_vx_out = r_s8_fric ? sat32(rnd16(50'(r_s8_pf))) : r_s8_vx;

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_s9_out.new_pos_x <= r_s8_x;
            r_s9_out.new_pos_y <= r_s8_y;
            r_s9_out.new_vel_x <= n_vx_out;
            r_s9_out.new_vel_y <= r_s8_vy;
            r_s9_out.retire    <= r_s8_ylow && r_s8_vy_half && below(n_vx_out, HALF_T);
        end
    end

    assign o_part.valid = r_vld[STAGES];
    assign o_part.data  = r_s9_out;

`ifndef ASSERT_OFF
    // input is refused only when every stage holds an item
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_part.ready |-> (&r_vld))
        else $error("input refused with a free pipeline stage");

    // delivered positions lie inside the walls
    a_in_walls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_part.valid |-> (!o_part.data.new_pos_x[31] && !o_part.data.new_pos_y[31]
                          && (o_part.data.new_pos_x <= r_xclamp)
                          && (o_part.data.new_pos_y <= r_yclamp)))
        else $error("result position outside the walls");

    // a retired particle is slow and near the floor
    a_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_part.valid && o_part.data.retire) |->
            (below(o_part.data.new_vel_x, HALF_T) && below(o_part.data.new_vel_y, HALF_T)
             && ((CMP_W + 1)'(o_part.data.new_pos_y) >= r_yret)))
        else $error("retire raised for a moving particle");

    // a result that is not taken stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_part.valid && !o_part.ready) |=> o_part.valid)
        else $error("result item lost while stalled");
`endif

endmodule
